// ===== hdl/dfr_pkg.sv =====
`default_nettype none

package dfr_pkg;

   // Configuration register indexes and port widths
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_BYTE     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD_LEN = 8'd1;

   localparam logic [7:0]  HEADER_BYTE_RESET     = 8'hA5;
   localparam logic [15:0] MAX_PAYLOAD_LEN_RESET = 16'd259;

   // Frame-end status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FCS_ERR  = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } dfr_status_type;

   // Live configuration seen by the parser
   typedef struct packed {
      logic [7:0]  header_byte;
      logic [15:0] max_payload_len;
   } dfr_cfg_type;

   // One result item
   typedef struct packed {
      logic           frame_end;
      logic [7:0]     command;
      logic [15:0]    length;
      logic [15:0]    byte_index;
      logic [7:0]     data_byte;
      dfr_status_type status;
   } dfr_result_type;

endpackage

`default_nettype wire

// ===== hdl/dfr_parser.sv =====
`default_nettype none

module dfr_parser
   import dfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     rx_byte,
   input  wire dfr_cfg_type    cfg,
   output logic                res_valid,
   output dfr_result_type      res
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_CMD   = 3'd1,
      ST_LEN_H = 3'd2,
      ST_LEN_L = 3'd3,
      ST_DATA  = 3'd4,
      ST_FCS   = 3'd5
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  fcs_ff, fcs_in;
   logic        hit;

   // Work out the next parse state and any result for this byte
   always_comb begin
      state_in   = state_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      fcs_in     = fcs_ff;
      hit        = 1'b0;
      res.frame_end  = 1'b0;
      res.command    = command_ff;
      res.length     = length_ff;
      res.byte_index = count_ff;
      res.data_byte  = rx_byte;
      res.status     = STATUS_OK;

      case (state_ff)
         ST_CMD: begin
            command_in = rx_byte;
            fcs_in     = rx_byte;
            state_in   = ST_LEN_H;
         end
         ST_LEN_H: begin
            length_in = {rx_byte, 8'h00};
            fcs_in    = fcs_ff ^ rx_byte;
            state_in  = ST_LEN_L;
         end
         ST_LEN_L: begin
            length_in = {length_ff[15:8], rx_byte};
            fcs_in    = fcs_ff ^ rx_byte;
            count_in  = 16'd0;
            state_in  = (length_in != 16'd0) ? ST_DATA : ST_FCS;
         end
         ST_DATA: begin
            fcs_in   = fcs_ff ^ rx_byte;
            hit      = (count_ff < cfg.max_payload_len);
            count_in = count_ff + 16'd1;
            if (count_in >= length_ff) begin
               state_in = ST_FCS;
            end
         end
         ST_FCS: begin
            hit            = 1'b1;
            res.frame_end  = 1'b1;
            res.byte_index = 16'd0;
            res.data_byte  = 8'd0;
            // too long wins over a checksum mismatch
            if (length_ff > cfg.max_payload_len) begin
               res.status = STATUS_TOO_LONG;
            end else if (fcs_ff != rx_byte) begin
               res.status = STATUS_FCS_ERR;
            end else begin
               res.status = STATUS_OK;
            end
            state_in = ST_IDLE;
         end
         default: begin
            // hunt for the header byte
            state_in = (rx_byte == cfg.header_byte) ? ST_CMD : ST_IDLE;
         end
      endcase
   end

   assign res_valid = accept & hit;

   // Advance the parse state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         command_ff <= 8'd0;
         length_ff  <= 16'd0;
         count_ff   <= 16'd0;
         fcs_ff     <= 8'd0;
      end else if (accept) begin
         state_ff   <= state_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         fcs_ff     <= fcs_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dfr_out_skid.sv =====
`default_nettype none

module dfr_out_skid
   import dfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   input  wire dfr_result_type in_data,
   input  wire logic           out_stall,
   output logic                out_valid,
   output dfr_result_type      out_data,
   output logic                full
);

   logic           main_valid_ff;
   dfr_result_type main_ff;
   logic           skid_valid_ff;
   dfr_result_type skid_ff;
   logic           main_free;

   // The output register frees up when empty or when its result is taken
   assign main_free = ~main_valid_ff | ~out_stall;

   // Control: no request is accepted while the skid stage holds a result
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         main_valid_ff <= skid_valid_ff | in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload: refill from the skid stage first, else park a new result in it
   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (in_valid) begin
         skid_ff <= in_data;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign full      = skid_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/xor_fcs_frame_deframer_top.sv =====
// Payload and frame-end results pass through the result register before reaching rsp_.
// Throughput: one byte per cycle while req_stall is low; parse state closes the only loop.
// A two-entry output (result register plus skid stage) lets requests flow while rsp_ stalls;
// req_stall rises only once both entries are full.
// Reset (synchronous): parser waits for a header, outputs empty, registers back to
// header 0xA5 and payload limit 259.
`default_nettype none

module xor_fcs_frame_deframer_top
   import dfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_frame_end,
   output logic [7:0]                  rsp_command,
   output logic [15:0]                 rsp_length,
   output logic [15:0]                 rsp_byte_index,
   output logic [7:0]                  rsp_data_byte,
   output logic [1:0]                  rsp_status,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   dfr_cfg_type    cfg_ff;
   logic           accept;
   logic           res_valid;
   dfr_result_type res;
   dfr_result_type out_data;
   logic           skid_full;

   // Configuration registers; writes to other indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte     <= HEADER_BYTE_RESET;
         cfg_ff.max_payload_len <= MAX_PAYLOAD_LEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_BYTE:     cfg_ff.header_byte     <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD_LEN: cfg_ff.max_payload_len <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = skid_full;
   assign accept    = req_valid & ~skid_full;

   dfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   dfr_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .full      (skid_full)
   );

   assign rsp_frame_end  = out_data.frame_end;
   assign rsp_command    = out_data.command;
   assign rsp_length     = out_data.length;
   assign rsp_byte_index = out_data.byte_index;
   assign rsp_data_byte  = out_data.data_byte;
   assign rsp_status     = out_data.status;

endmodule

`default_nettype wire

// ===== hdl/dfr_checker.sv =====
`default_nettype none

module dfr_checker
   import dfr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_frame_end,
   input wire logic [15:0] rsp_length,
   input wire logic [15:0] rsp_byte_index,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic [1:0]  rsp_status
);

   // Hold a stalled result on the result side
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_byte_index) && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // Payload results carry ok status and an index inside the declared length
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_status == STATUS_OK)
      else $error("payload result with non-ok status");

   a_payload_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_end |-> rsp_byte_index < rsp_length)
      else $error("payload index beyond declared length");

   // Frame-end results carry zero index and data
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_byte_index == 16'd0 && rsp_data_byte == 8'd0)
      else $error("frame end with non-zero index or data");

endmodule

bind xor_fcs_frame_deframer_top dfr_checker u_dfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_frame_end  (rsp_frame_end),
   .rsp_length     (rsp_length),
   .rsp_byte_index (rsp_byte_index),
   .rsp_data_byte  (rsp_data_byte),
   .rsp_status     (rsp_status)
);

`default_nettype wire
